>>> src/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

    // Default screen geometry
    localparam int DEF_SCREEN_WIDTH  = 80;
    localparam int DEF_SCREEN_HEIGHT = 25;

    // Style byte after reset
    localparam logic [7:0] DEFAULT_STYLE_RESET = 8'd7;

    // Character code that starts a new row
    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // Item kinds
    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
        logic [4:0] cell_row;
        logic [6:0] cell_col;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_char;
        logic [7:0] read_style;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic       scrolled;
    } out_item_t;

endpackage

`default_nettype wire

>>> src/tcw_ram.sv
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> src/tcw_addr_unit.sv
`default_nettype none

// Shared cell address unit: y = a * SCREEN_WIDTH + b
module tcw_addr_unit #(
    parameter int SCREEN_WIDTH = 80,
    parameter int A_W          = 5,
    parameter int B_W          = 12,
    parameter int Y_W          = 12
) (
    input  wire logic [A_W-1:0] a,
    input  wire logic [B_W-1:0] b,
    output logic      [Y_W-1:0] y
);

    logic [31:0] prod;

    assign prod = 32'(a) * 32'(SCREEN_WIDTH);
    assign y    = Y_W'(prod + 32'(b));

endmodule

`default_nettype wire

>>> src/tcw_seq.sv
`default_nettype none

module tcw_seq
    import tcw_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    localparam int N   = SCREEN_WIDTH * SCREEN_HEIGHT,
    localparam int AW  = $clog2(N),
    localparam int RW  = $clog2(SCREEN_HEIGHT),
    localparam int CW  = $clog2(SCREEN_WIDTH),
    localparam int A_W = (RW > 5) ? RW : 5,
    localparam int B_W = (AW + 1 > 8) ? AW + 1 : 8,
    localparam int Y_W = AW + 1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire in_item_t       item,
    input  wire logic [7:0]     default_style,
    output logic                busy,
    // shared address unit
    output logic      [A_W-1:0] ua,
    output logic      [B_W-1:0] ub,
    input  wire logic [Y_W-1:0] uy,
    // screen memory
    output logic                wr_en,
    output logic      [AW-1:0]  wr_addr,
    output logic      [15:0]    wr_data,
    output logic      [AW-1:0]  rd_addr,
    input  wire logic [15:0]    rd_data,
    // result
    output out_item_t           res,
    output logic                res_load
);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_CALC   = 7'b0000100,
        S_PUT    = 7'b0001000,
        S_RD     = 7'b0010000,
        S_SCROLL = 7'b0100000,
        S_FILL   = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    in_item_t        item_reg, item_next;

    logic            row_last;
    logic            col_last;
    logic            sweep_last;
    logic            cell_ok;
    logic [B_W-1:0]  cnt_inc;
    logic [15:0]     blank;

    assign busy       = (state_reg != S_IDLE);
    assign row_last   = (row_reg == RW'(SCREEN_HEIGHT - 1));
    assign col_last   = (col_reg == CW'(SCREEN_WIDTH - 1));
    assign sweep_last = (cnt_reg == AW'(N - 1));
    assign cnt_inc    = B_W'(cnt_reg) + B_W'(1);
    assign blank      = {default_style, 8'h00};
    assign cell_ok    = (32'(item_reg.cell_row) < 32'(SCREEN_HEIGHT))
                     && (32'(item_reg.cell_col) < 32'(SCREEN_WIDTH));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        addr_next  = addr_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        item_next  = item_reg;
        ua         = '0;
        ub         = '0;
        wr_en      = 1'b0;
        wr_addr    = cnt_reg;
        wr_data    = '0;
        rd_addr    = '0;
        res_load   = 1'b0;
        res        = '0;

        unique case (state_reg)
            S_INIT:
            begin
                // wipe the screen to zero after reset
                wr_en = 1'b1;
                if (sweep_last)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = AW'(cnt_inc);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                case (item_reg.kind)
                    KIND_PUT:
                    begin
                        if (item_reg.char_code == NEWLINE_CODE)
                        begin
                            col_next = '0;
                            // read ahead of a possible scroll: second row
                            ua      = A_W'(1);
                            rd_addr = AW'(uy);
                            if (row_last)
                            begin
                                cnt_next   = '0;
                                state_next = S_SCROLL;
                            end
                            else
                            begin
                                row_next   = RW'(row_reg + RW'(1));
                                res_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            ua         = A_W'(row_reg);
                            ub         = B_W'(col_reg);
                            rd_addr    = AW'(uy);
                            addr_next  = AW'(uy);
                            state_next = S_PUT;
                        end
                    end
                    KIND_READ:
                    begin
                        ua = A_W'(item_reg.cell_row);
                        ub = B_W'(item_reg.cell_col);
                        if (cell_ok)
                        begin
                            rd_addr    = AW'(uy);
                            state_next = S_RD;
                        end
                        else
                        begin
                            res_load   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        cnt_next   = '0;
                        state_next = S_FILL;
                    end
                    default:
                    begin
                        res_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_PUT:
            begin
                // keep the cell's style, replace the character
                wr_en   = 1'b1;
                wr_addr = addr_reg;
                wr_data = {rd_data[15:8], item_reg.char_code};
                ua      = A_W'(1);
                rd_addr = AW'(uy);
                if (!col_last)
                begin
                    col_next   = CW'(col_reg + CW'(1));
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    col_next = '0;
                    if (row_last)
                    begin
                        cnt_next   = '0;
                        state_next = S_SCROLL;
                    end
                    else
                    begin
                        row_next   = RW'(row_reg + RW'(1));
                        res_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_RD:
            begin
                res.read_char  = rd_data[7:0];
                res.read_style = rd_data[15:8];
                res_load       = 1'b1;
                state_next     = S_IDLE;
            end
            S_SCROLL:
            begin
                // write cell cnt from cell cnt+W, read one ahead
                wr_en   = 1'b1;
                wr_data = (32'(cnt_reg) < 32'(N - SCREEN_WIDTH)) ? rd_data : blank;
                ua      = A_W'(1);
                ub      = cnt_inc;
                rd_addr = (32'(uy) < 32'(N)) ? AW'(uy) : '0;
                if (sweep_last)
                begin
                    cnt_next     = '0;
                    res.scrolled = 1'b1;
                    res_load     = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cnt_next = AW'(cnt_inc);
                end
            end
            S_FILL:
            begin
                wr_en   = 1'b1;
                wr_data = blank;
                if (sweep_last)
                begin
                    cnt_next   = '0;
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = AW'(cnt_inc);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.cursor_row = 5'(row_next);
        res.cursor_col = 7'(col_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        item_reg <= item_next;
    end

`ifndef SYNTHESIS
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(row_reg) < 32'(SCREEN_HEIGHT)) && (32'(col_reg) < 32'(SCREEN_WIDTH)))
        else $error("cursor left the screen");

    a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg == S_CALC))
        else $error("accepted transaction did not reach address phase");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_CALC || state_reg == S_RD) |-> !wr_en)
        else $error("screen write outside a write phase");

    a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT || state_reg == S_IDLE) |-> !res_load)
        else $error("result issued without a transaction");

    a_scroll_on_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCROLL) |-> (row_last && col_reg == '0))
        else $error("scroll with cursor off the bottom row start");
`endif

endmodule

`default_nettype wire

>>> src/text_console_writer_unit.sv
// Text-mode console writer: SCREEN_HEIGHT rows by SCREEN_WIDTH columns of
// 16-bit cells (character in the low byte, style in the high byte).
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. kind selects put character, read cell or clear screen.
// Result channel: done is high for exactly one cycle with result valid;
// there is no back-pressure, the receiver must take it in that cycle.
// Config channel: cfg_valid/cfg_data write the default style byte; cfg_ready
// is always high, so a write completes in the cycle it is offered.
//
// States passed through after the accepting edge, before done is raised:
//   newline (no scroll), unused kind, out-of-screen read : S_CALC
//   ordinary character (no scroll), valid read          : S_CALC, S_PUT/S_RD
//   scroll adds an S_SCROLL pass over every cell (one cell per cycle)
//   clear: S_CALC, then an S_FILL pass over every cell
// The single port pair of the screen RAM and the shared address unit set
// these steps; busy is high for the whole transaction, so a new command
// can be taken in the cycle done is shown.
// Reset: cursor to (0,0), default style 7, then a clearing pass writes zero
// to all SCREEN_WIDTH*SCREEN_HEIGHT cells, one per cycle, with busy high.
`default_nettype none

module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // command
    input  wire logic       start,
    input  wire in_item_t   item,
    output logic            busy,
    // result
    output logic            done,
    output out_item_t       result,
    // configuration
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    localparam int N   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW  = $clog2(N);
    localparam int RW  = $clog2(SCREEN_HEIGHT);
    localparam int A_W = (RW > 5) ? RW : 5;
    localparam int B_W = (AW + 1 > 8) ? AW + 1 : 8;
    localparam int Y_W = AW + 1;

    logic [7:0]     style_reg, style_next;
    out_item_t      result_reg;
    logic           done_reg;

    logic [A_W-1:0] ua;
    logic [B_W-1:0] ub;
    logic [Y_W-1:0] uy;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [15:0]    wr_data;
    logic [AW-1:0]  rd_addr;
    logic [15:0]    rd_data;
    out_item_t      res;
    logic           res_load;

    // style register accepts writes at any time
    assign cfg_ready  = 1'b1;
    assign style_next = (cfg_valid && cfg_ready) ? cfg_data : style_reg;

    tcw_seq #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .item          (item),
        .default_style (style_reg),
        .busy          (busy),
        .ua            (ua),
        .ub            (ub),
        .uy            (uy),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .res           (res),
        .res_load      (res_load)
    );

    tcw_addr_unit #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .A_W          (A_W),
        .B_W          (B_W),
        .Y_W          (Y_W)
    ) u_addr (
        .a (ua),
        .b (ub),
        .y (uy)
    );

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (N)
    ) u_screen (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            style_reg <= DEFAULT_STYLE_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            style_reg <= style_next;
            done_reg  <= res_load;
        end
    end

    // result payload, held until the next transaction completes
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            result_reg <= res;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> tb/text_console_checker.sv
module text_console_checker
    import tcw_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  in_item_t   item,
    input  logic       done,
    input  out_item_t  result,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending,
    output int         results_seen,
    output int         scrolls_seen,
    output int         clears_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;

    // shadow screen: char in [7:0], style in [15:8]
    logic [15:0] screen [CELL_COUNT];
    int          cur_row;
    int          cur_col;
    logic [7:0]  blank_style;
    out_item_t   expected_results [$];

    function automatic void blank_cells(int first, int count);
        for (int i = 0; i < count; i++)
            screen[first + i] = {blank_style, 8'h00};
    endfunction

    function automatic out_item_t predict_command(in_item_t cmd);
        out_item_t res;
        int        at;
        res = '0;
        case (cmd.kind)
            KIND_PUT:
            begin
                if (cmd.char_code == NEWLINE_CODE)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                else
                begin
                    at = cur_row * SCREEN_WIDTH + cur_col;
                    if (at < CELL_COUNT)
                        screen[at][7:0] = cmd.char_code;
                    if (cur_col < SCREEN_WIDTH - 1)
                        cur_col++;
                    else
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
                if (cur_row > SCREEN_HEIGHT - 1)
                begin
                    for (int i = 0; i < SCREEN_WIDTH * (SCREEN_HEIGHT - 1); i++)
                        screen[i] = screen[i + SCREEN_WIDTH];
                    blank_cells(SCREEN_WIDTH * (SCREEN_HEIGHT - 1), SCREEN_WIDTH);
                    cur_row      = SCREEN_HEIGHT - 1;
                    res.scrolled = 1'b1;
                end
            end
            KIND_READ:
            begin
                if (cmd.cell_row < SCREEN_HEIGHT && cmd.cell_col < SCREEN_WIDTH)
                begin
                    at             = cmd.cell_row * SCREEN_WIDTH + cmd.cell_col;
                    res.read_char  = screen[at][7:0];
                    res.read_style = screen[at][15:8];
                end
            end
            KIND_CLEAR:
                blank_cells(0, CELL_COUNT);
            default:
                ;
        endcase
        res.cursor_row = cur_row[4:0];
        res.cursor_col = cur_col[6:0];
        return res;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t pred;
        if (!rst_n)
        begin
            for (int i = 0; i < CELL_COUNT; i++)
                screen[i] = '0;
            cur_row     = 0;
            cur_col     = 0;
            blank_style = DEFAULT_STYLE_RESET;
            expected_results.delete();
            fail_count   = 0;
            results_seen = 0;
            scrolls_seen = 0;
            clears_seen  = 0;
        end
        else
        begin
            // result first: a new command may be taken in the done cycle
            if (done === 1'b1)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result: strobe with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_char", want.read_char, result.read_char);
                    check_field("read_style", want.read_style, result.read_style);
                    check_field("cursor_row", 8'(want.cursor_row), 8'(result.cursor_row));
                    check_field("cursor_col", 8'(want.cursor_col), 8'(result.cursor_col));
                    check_field("scrolled", 8'(want.scrolled), 8'(result.scrolled));
                end
            end
            if (start && !busy)
            begin
                pred = predict_command(item);
                if (pred.scrolled)
                    scrolls_seen++;
                if (item.kind == KIND_CLEAR)
                    clears_seen++;
                expected_results.push_back(pred);
            end
            if (cfg_valid && cfg_ready)
                blank_style = cfg_data;
        end
        pending = expected_results.size();
    end

endmodule

>>> tb/tb_text_console_writer_unit.sv
module tb_text_console_writer_unit
    import tcw_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Kind code the block must treat as a no-op
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 200;
    // every command returns a result, so a short drain is enough to catch
    // any stray strobe after the last one
    localparam int TAIL_CYCLES     = 16;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    in_item_t   cmd;
    logic       busy;
    logic       done;
    out_item_t  result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    int fail_count;
    int pending;
    int results_seen;
    int scrolls_seen;
    int clears_seen;

    text_console_writer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Predicts every accepted transaction and scores the result strobes
    text_console_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (cmd),
        .done         (done),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .scrolls_seen (scrolls_seen),
        .clears_seen  (clears_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic in_item_t mk(logic [1:0] kind, logic [7:0] code,
                                    logic [4:0] row, logic [6:0] col);
        in_item_t c;
        c.kind      = kind;
        c.char_code = code;
        c.cell_row  = row;
        c.cell_col  = col;
        return c;
    endfunction

    // Mostly puts, so the cursor reaches the bottom and scrolls often.
    // nl_odds sets the newline rate: low for frequent line ends, high so
    // that long runs of characters wrap at the last column.
    function automatic in_item_t build_random_command(int nl_odds);
        in_item_t c;
        int       pick;
        c    = mk(KIND_PUT, 8'($urandom_range(255)), 5'($urandom_range(31)),
                  7'($urandom_range(127)));
        pick = $urandom_range(99);
        if (pick < 65)
        begin
            if ($urandom_range(nl_odds) == 0)
                c.char_code = NEWLINE_CODE;
        end
        else if (pick < 92)
        begin
            c.kind = KIND_READ;
            // bottom row is where the writing happens once scrolling starts
            if ($urandom_range(9) < 3)
                c.cell_row = 5'(DEF_SCREEN_HEIGHT - 1);
            else if ($urandom_range(9) < 8)
                c.cell_row = 5'($urandom_range(DEF_SCREEN_HEIGHT - 1));
            if ($urandom_range(9) < 8)
                c.cell_col = 7'($urandom_range(DEF_SCREEN_WIDTH - 1));
        end
        else if (pick < 95)
            c.kind = KIND_CLEAR;
        else
            c.kind = KIND_UNUSED;
        return c;
    endfunction

    // Holds start high until the transaction is taken. start is left high
    // on return so back-to-back commands need no extra edge.
    task automatic issue(in_item_t c);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_gap(int pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Settled values are sampled on the falling edge, then realign to the
    // rising edge for driving.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (busy || pending != 0);
        @(posedge clk);
    endtask

    task automatic write_style(logic [7:0] style);
        cfg_valid <= 1'b1;
        cfg_data  <= style;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int         idle_pct [N_PHASES];
        logic [7:0] style;

        idle_pct  = '{0, 87, 6, 0, 87, 6};
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // covers the clearing pass that follows reset
        wait_idle();

        // Directed: untouched cells, edge and off-screen reads, odd codes,
        // ignored fields, the unused kind, newline and clear
        issue(mk(KIND_READ, 8'h00, 5'd0, 7'd0));
        issue(mk(KIND_READ, 8'hFF, 5'd24, 7'd79));
        issue(mk(KIND_READ, 8'h00, 5'd25, 7'd0));
        issue(mk(KIND_READ, 8'h00, 5'd0, 7'd80));
        issue(mk(KIND_READ, 8'h00, 5'd31, 7'd127));
        issue(mk(KIND_PUT, 8'h41, 5'd31, 7'd127));
        issue(mk(KIND_PUT, 8'h00, 5'd0, 7'd0));
        issue(mk(KIND_PUT, 8'd37, 5'd0, 7'd0));
        issue(mk(KIND_PUT, 8'hFF, 5'd0, 7'd0));
        issue(mk(KIND_READ, 8'hFF, 5'd0, 7'd0));
        issue(mk(KIND_READ, 8'h00, 5'd0, 7'd1));
        issue(mk(KIND_READ, 8'h00, 5'd0, 7'd2));
        issue(mk(KIND_READ, 8'h00, 5'd0, 7'd3));
        issue(mk(KIND_UNUSED, 8'hFF, 5'h1F, 7'h7F));
        issue(mk(KIND_PUT, NEWLINE_CODE, 5'd0, 7'd0));
        issue(mk(KIND_READ, 8'h00, 5'd1, 7'd0));
        issue(mk(KIND_CLEAR, 8'hFF, 5'h1F, 7'h7F));
        issue(mk(KIND_READ, 8'h00, 5'd0, 7'd0));
        issue(mk(KIND_READ, 8'h00, 5'd24, 7'd79));
        // style of the cell under the cursor must survive a put
        issue(mk(KIND_PUT, 8'h7E, 5'd0, 7'd0));
        issue(mk(KIND_READ, 8'h00, 5'd1, 7'd0));
        start <= 1'b0;

        // Random phases: new default style each time (extremes first),
        // varying sender gaps and newline density
        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:       style = 8'h00;
                1:       style = 8'hFF;
                3:       style = 8'h80;
                default: style = 8'($urandom_range(255));
            endcase
            wait_idle();
            write_style(style);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                issue(build_random_command((p % 2 == 0) ? 3 : 199));
                idle_gap(idle_pct[p]);
            end
            start <= 1'b0;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d result transactions over %0d style settings and sender gap mixes.",
                 results_seen, N_PHASES);
        $display("The screen scrolled %0d times and was cleared %0d times.",
                 scrolls_seen, clears_seen);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hang guard: far beyond a run where every command took a full clear
    initial
    begin
        #100ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
